// ----- hw/rtl/thl_pkg.sv -----
// ----------------------------------------------------------------------------
// thl_pkg
// Types and constants for the three-level light classifier with hysteresis.
// ----------------------------------------------------------------------------
package thl_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned ACT_W    = 12;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        LVL_LOW    = 2'd0,
        LVL_MEDIUM = 2'd1,
        LVL_HIGH   = 2'd2
    } level_t;

    localparam logic [2:0] CAP_NONE         = 3'd0;
    localparam logic [2:0] CAP_LOW_SET      = 3'd1;
    localparam logic [2:0] CAP_HIGH_INSTEAD = 3'd2;
    localparam logic [2:0] CAP_HIGH_SET     = 3'd3;
    localparam logic [2:0] CAP_LOW_INSTEAD  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HIGH = 2'd2;

    localparam logic [SAMPLE_W-1:0] RST_MARGIN       = 10'd30;
    localparam logic [SAMPLE_W-1:0] RST_DEFAULT_LOW  = 10'd135;
    localparam logic [SAMPLE_W-1:0] RST_DEFAULT_HIGH = 10'd420;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                low_button;
        logic                high_button;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          level;
        logic                level_changed;
        logic [2:0]          capture_event;
        logic                bases_restored;
        logic [SAMPLE_W-1:0] base_low;
        logic [SAMPLE_W-1:0] base_high;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] margin;
        logic [SAMPLE_W-1:0] default_low;
        logic [SAMPLE_W-1:0] default_high;
    } cfg_t;

    typedef struct packed {
        logic signed [ACT_W-1:0] active_low;
        logic signed [ACT_W-1:0] active_high;
        logic [SAMPLE_W-1:0]     base_low;
        logic [SAMPLE_W-1:0]     base_high;
        level_t                  level;
        logic                    low_button_prev;
        logic                    high_button_prev;
    } state_t;

endpackage

// ----- hw/rtl/thl_core.sv -----
// ----------------------------------------------------------------------------
// thl_core
// Per-item next-state and result logic: button capture, base restore,
// threshold hysteresis and level classification.
// ----------------------------------------------------------------------------
module thl_core (
    input  thl_pkg::state_t    st,
    input  thl_pkg::in_item_t  item,
    input  thl_pkg::cfg_t      cfg,
    output thl_pkg::state_t    st_next,
    output thl_pkg::out_item_t res
);
    import thl_pkg::*;

    logic signed [ACT_W-1:0] s;
    logic signed [ACT_W-1:0] m;
    logic signed [ACT_W-1:0] al;
    logic signed [ACT_W-1:0] ah;
    logic signed [ACT_W-1:0] bl;
    logic signed [ACT_W-1:0] bh;
    logic signed [ACT_W-1:0] gap;
    logic [2:0]              ev;
    logic                    restored;
    logic                    low_edge;
    logic                    high_edge;
    level_t                  lvl;

    assign low_edge  = item.low_button & ~st.low_button_prev;
    assign high_edge = item.high_button & ~st.high_button_prev;
    assign s = $signed({2'b00, item.sample});
    assign m = $signed({2'b00, cfg.margin});

    always_comb begin
        al       = st.active_low;
        ah       = st.active_high;
        bl       = $signed({2'b00, st.base_low});
        bh       = $signed({2'b00, st.base_high});
        ev       = CAP_NONE;
        restored = 1'b0;
        lvl      = st.level;

        if (low_edge) begin
            if (s < ah) begin
                al = s;
                bl = s;
                ev = CAP_LOW_SET;
            end else begin
                ah = s;
                bh = s;
                ev = CAP_HIGH_INSTEAD;
            end
        end

        // high capture sees the low capture of the same item
        if (high_edge) begin
            if (s > al) begin
                ah = s;
                bh = s;
                ev = CAP_HIGH_SET;
            end else begin
                al = s;
                bl = s;
                ev = CAP_LOW_INSTEAD;
            end
        end

        gap = bh - bl;
        if (gap <= m) begin
            bl       = $signed({2'b00, cfg.default_low});
            bh       = $signed({2'b00, cfg.default_high});
            al       = bl;
            ah       = bh;
            restored = 1'b1;
        end

        // return to base once the sample is a full margin away
        if (s >= bl + m || s <= bl - m) begin
            al = bl;
        end
        if (s >= bh + m || s <= bh - m) begin
            ah = bh;
        end

        if (s < al && st.level != LVL_LOW) begin
            if (st.level == LVL_MEDIUM) begin
                al = bl + m;
            end
            lvl = LVL_LOW;
        end else if (s >= al && s < ah && st.level != LVL_MEDIUM) begin
            if (st.level == LVL_LOW) begin
                al = bl - m;
            end
            if (st.level == LVL_HIGH) begin
                ah = bh + m;
            end
            lvl = LVL_MEDIUM;
        end else if (s >= ah && st.level != LVL_HIGH) begin
            if (st.level == LVL_MEDIUM) begin
                ah = bh - m;
            end
            lvl = LVL_HIGH;
        end
    end

    always_comb begin
        st_next.active_low       = al;
        st_next.active_high      = ah;
        st_next.base_low         = bl[SAMPLE_W-1:0];
        st_next.base_high        = bh[SAMPLE_W-1:0];
        st_next.level            = lvl;
        st_next.low_button_prev  = item.low_button;
        st_next.high_button_prev = item.high_button;

        res.level          = lvl;
        res.level_changed  = (lvl != st.level);
        res.capture_event  = ev;
        res.bases_restored = restored;
        res.base_low       = bl[SAMPLE_W-1:0];
        res.base_high      = bh[SAMPLE_W-1:0];
    end

endmodule

// ----- hw/rtl/three_level_hysteresis_classifier_top.sv -----
// Each accepted item is held in the input register; its result is registered when it moves on.
// Throughput: one item per cycle while the output is not stalled; the classifier state loop
// closes through the core logic between the input and result registers.
// Reset (aresetn low, synchronous): bases 135/420, margin 30, level medium,
// both pipeline registers empty; configuration writes are always accepted.
// ----------------------------------------------------------------------------
// three_level_hysteresis_classifier_top
// Light sample classifier with button-captured thresholds and hysteresis.
// ----------------------------------------------------------------------------
module three_level_hysteresis_classifier_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  thl_pkg::in_item_t                    s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output thl_pkg::out_item_t                   m_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [thl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [thl_pkg::SAMPLE_W-1:0]         cfg_data
);
    import thl_pkg::*;

    cfg_t      cfg_reg;
    state_t    st_reg;
    state_t    st_next;
    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;
    logic      out_valid_reg;
    logic      advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.margin       <= RST_MARGIN;
            cfg_reg.default_low  <= RST_DEFAULT_LOW;
            cfg_reg.default_high <= RST_DEFAULT_HIGH;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MARGIN:       cfg_reg.margin       <= cfg_data;
                CFG_DEFAULT_LOW:  cfg_reg.default_low  <= cfg_data;
                CFG_DEFAULT_HIGH: cfg_reg.default_high <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register: take a new item when empty or whenever the held one moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_reg <= s_item;
        end
    end

    thl_core u_core (
        .st      (st_reg),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .st_next (st_next),
        .res     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.active_low       <= $signed({2'b00, RST_DEFAULT_LOW});
            st_reg.active_high      <= $signed({2'b00, RST_DEFAULT_HIGH});
            st_reg.base_low         <= RST_DEFAULT_LOW;
            st_reg.base_high        <= RST_DEFAULT_HIGH;
            st_reg.level            <= LVL_MEDIUM;
            st_reg.low_button_prev  <= 1'b0;
            st_reg.high_button_prev <= 1'b1;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_level_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.level != 2'd3)
        else $error("result level out of range");

    a_level_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.level == st_reg.level)
        else $error("pending result level differs from state");

    a_bases_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.bases_restored) |-> m_item.base_high > m_item.base_low)
        else $error("bases out of order without restore");
`endif

endmodule
